// ----- hw/rtl/r2h_pkg.sv -----
// Shared types, constants and helper functions for the RGB to HSV converter.
`default_nettype none

package r2h_pkg;

  // Channel and arithmetic widths
  localparam int CH_W       = 8;
  localparam int SAT_QB     = 8;    // saturation quotient bits (result <= 255)
  localparam int HUE_QB     = 6;    // hue offset quotient bits (result <= 43)
  localparam int SAT_NUM_W  = 16;   // 255 * delta fits in 16 bits
  localparam int HUE_NUM_W  = 14;   // 43 * |diff| fits in 14 bits
  localparam int STEP_IDX_W = $clog2(SAT_QB);

  // Scale constants
  localparam int HUE_SECTOR     = 43;
  localparam int HUE_BASE_GREEN = 85;
  localparam int HUE_BASE_BLUE  = 171;
  localparam int FULL_SCALE     = 255;

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Result of the max/min classification
  typedef struct packed {
    logic [CH_W-1:0] value;
    logic [CH_W-1:0] delta;
    sector_t         sector;
    logic            neg;
    logic [CH_W-1:0] absdiff;
    logic            grey;
  } pix_class_t;

  // Working set carried through the divider stages
  typedef struct packed {
    logic [CH_W-1:0]      value;
    logic [CH_W-1:0]      delta;
    sector_t              sector;
    logic                 neg;
    logic                 grey;
    logic [SAT_NUM_W-1:0] sat_rem;
    logic [SAT_QB-1:0]    sat_q;
    logic [HUE_NUM_W-1:0] hue_rem;
    logic [HUE_QB-1:0]    hue_q;
  } div_stage_t;

  // Hue base for each sector
  function automatic logic [CH_W-1:0] hue_base(input sector_t sec);
    logic [CH_W-1:0] b;
    b = '0;
    unique case (sec)
      SEC_RED:   b = '0;
      SEC_GREEN: b = CH_W'(HUE_BASE_GREEN);
      SEC_BLUE:  b = CH_W'(HUE_BASE_BLUE);
      default:   b = '0;
    endcase
    return b;
  endfunction

  // One restoring step of both dividers at quotient bit bit_idx.
  // Saturation divides by value, hue offset divides by delta.
  function automatic div_stage_t div_step(input div_stage_t s,
                                          input logic [STEP_IDX_W-1:0] bit_idx);
    div_stage_t           t;
    logic [SAT_NUM_W-1:0] sd;
    logic [HUE_NUM_W-1:0] hd;
    t  = s;
    sd = SAT_NUM_W'(s.value) << bit_idx;
    hd = HUE_NUM_W'(s.delta) << bit_idx;
    if (s.sat_rem >= sd) begin
      t.sat_rem        = s.sat_rem - sd;
      t.sat_q[bit_idx] = 1'b1;
    end
    if (int'(bit_idx) < HUE_QB) begin
      if (s.hue_rem >= hd) begin
        t.hue_rem        = s.hue_rem - hd;
        t.hue_q[bit_idx] = 1'b1;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/r2h_classify.sv -----
// Max/min search, sector choice and signed hue difference for one pixel.
`default_nettype none

module r2h_classify (
  input  wire logic [r2h_pkg::CH_W-1:0] red,
  input  wire logic [r2h_pkg::CH_W-1:0] green,
  input  wire logic [r2h_pkg::CH_W-1:0] blue,
  output r2h_pkg::pix_class_t           cls
);
  import r2h_pkg::*;

  logic [CH_W-1:0] hi;
  logic [CH_W-1:0] lo;
  logic [CH_W-1:0] rg_hi;
  logic [CH_W-1:0] rg_lo;
  logic [CH_W-1:0] op_a;
  logic [CH_W-1:0] op_b;
  sector_t         sec;

  // Largest and smallest channel
  assign rg_hi = (red > green) ? red : green;
  assign rg_lo = (red < green) ? red : green;
  assign hi    = (rg_hi > blue) ? rg_hi : blue;
  assign lo    = (rg_lo < blue) ? rg_lo : blue;

  // Sector, ties to red then green
  always_comb begin
    priority if (red == hi) begin
      sec = SEC_RED;
    end else if (green == hi) begin
      sec = SEC_GREEN;
    end else begin
      sec = SEC_BLUE;
    end
  end

  // Operands of the signed difference for each sector
  always_comb begin
    unique case (sec)
      SEC_RED: begin
        op_a = green;
        op_b = blue;
      end
      SEC_GREEN: begin
        op_a = blue;
        op_b = red;
      end
      default: begin
        op_a = red;
        op_b = green;
      end
    endcase
  end

  always_comb begin
    cls.value   = hi;
    cls.delta   = hi - lo;
    cls.sector  = sec;
    cls.neg     = (op_a < op_b);
    cls.absdiff = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    cls.grey    = (hi == lo);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_8bit.sv -----
// Top level: pipelined 8-bit RGB to HSV converter.
// Each accepted input beat passes through registered stages to its output beat
// (classify, numerator prep, 8 restoring divider steps, output register).
// Throughput: one pixel per cycle while the output is not stalled; the 8-step saturation divider sets the depth.
// Bubbles are squeezed out per stage when the output is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none

module rgb_to_hsv_8bit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [r2h_pkg::CH_W-1:0] in_red,
  input  wire logic [r2h_pkg::CH_W-1:0] in_green,
  input  wire logic [r2h_pkg::CH_W-1:0] in_blue,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [r2h_pkg::CH_W-1:0]      out_hue,
  output logic [r2h_pkg::CH_W-1:0]      out_saturation,
  output logic [r2h_pkg::CH_W-1:0]      out_value
);
  import r2h_pkg::*;

  // Stage map: 0 classify, 1 prep, 2..SAT_QB+1 divider, last output
  localparam int N_STG = SAT_QB + 3;
  localparam int OUT_S = N_STG - 1;

  logic [N_STG-1:0] vld_r;
  logic [N_STG-1:0] adv;

  pix_class_t      cls_c;
  pix_class_t      cls_r;
  div_stage_t      prep_nxt;
  div_stage_t      prep_r;
  div_stage_t      div_r [SAT_QB];
  logic [CH_W-1:0] q_ext;
  logic [CH_W-1:0] hue_off;
  logic [CH_W-1:0] hue_nxt;
  logic [CH_W-1:0] hue_r;
  logic [CH_W-1:0] sat_r;
  logic [CH_W-1:0] val_r;

  // Advance chain: a stage loads when empty or when its successor moves
  assign adv[OUT_S] = ~vld_r[OUT_S] | ~out_stall;
  for (genvar i = 0; i < OUT_S; i++) begin : g_adv
    assign adv[i] = ~vld_r[i] | adv[i+1];
  end

  assign in_stall = ~adv[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < N_STG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 0: classify the incoming beat
  r2h_classify u_classify (
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .cls   (cls_c)
  );

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cls_r <= cls_c;
    end
  end

  // Stage 1: numerators 255*delta and 43*|diff|
  always_comb begin
    prep_nxt.value   = cls_r.value;
    prep_nxt.delta   = cls_r.delta;
    prep_nxt.sector  = cls_r.sector;
    prep_nxt.neg     = cls_r.neg;
    prep_nxt.grey    = cls_r.grey;
    prep_nxt.sat_rem = (SAT_NUM_W'(cls_r.delta) << CH_W) - SAT_NUM_W'(cls_r.delta);
    prep_nxt.sat_q   = '0;
    prep_nxt.hue_rem = HUE_NUM_W'(cls_r.absdiff) * HUE_NUM_W'(HUE_SECTOR);
    prep_nxt.hue_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prep_r <= prep_nxt;
    end
  end

  // Divider stages: one quotient bit per stage, MSB first
  for (genvar j = 0; j < SAT_QB; j++) begin : g_div
    localparam logic [STEP_IDX_W-1:0] BIT = STEP_IDX_W'(SAT_QB - 1 - j);
    div_stage_t src;
    if (j == 0) begin : g_first
      assign src = prep_r;
    end else begin : g_next
      assign src = div_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv[j+2]) begin
        div_r[j] <= div_step(src, BIT);
      end
    end
  end

  // Output stage: signed offset onto the sector base, wrap mod 256; grey pixels give zero hue and saturation
  assign q_ext   = CH_W'(div_r[SAT_QB-1].hue_q);
  assign hue_off = div_r[SAT_QB-1].neg ? (~q_ext + CH_W'(1)) : q_ext;
  assign hue_nxt = hue_base(div_r[SAT_QB-1].sector) + hue_off;

  always_ff @(posedge clk) begin
    if (adv[OUT_S]) begin
      hue_r <= div_r[SAT_QB-1].grey ? '0 : hue_nxt;
      sat_r <= div_r[SAT_QB-1].grey ? '0 : div_r[SAT_QB-1].sat_q;
      val_r <= div_r[SAT_QB-1].value;
    end
  end

  assign out_valid      = vld_r[OUT_S];
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_value      = val_r;

endmodule

`default_nettype wire

// ----- test/rgb_to_hsv_8bit_tb.sv -----
// Self-checking testbench for the pipelined 8-bit RGB to HSV converter.
`default_nettype none

module rgb_to_hsv_8bit_tb;

  localparam int W             = r2h_pkg::CH_W;
  localparam int RANDOM_PIXELS = 1530;
  localparam int DRAIN_CYCLES  = 30;      // well past the pipeline depth
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [W-1:0] hue;
    logic [W-1:0] saturation;
    logic [W-1:0] value;
  } hsv_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {PIX_ANY, PIX_NEAR_GREY, PIX_TIE, PIX_RAIL, PIX_DARK, PIX_GREY} pix_kind_t;

  // Holds the HSV triples still owed by the block, oldest first
  class hsv_scoreboard;
    hsv_t        pending_hsv[$];
    int unsigned mismatches   = 0;
    int unsigned pixels_in    = 0;
    int unsigned results_seen = 0;

    // Integer HSV of one pixel; hue wraps modulo 256, quotient truncates toward zero
    function hsv_t pixel_to_hsv(logic [W-1:0] r, logic [W-1:0] g, logic [W-1:0] b);
      hsv_t              res;
      int                ri, gi, bi, hi, lo, delta, base, diff, hue;
      r2h_pkg::sector_t  sec;
      ri = r;
      gi = g;
      bi = b;
      hi = (ri > gi) ? ri : gi;
      hi = (hi > bi) ? hi : bi;
      lo = (ri < gi) ? ri : gi;
      lo = (lo < bi) ? lo : bi;
      delta = hi - lo;
      hue   = 0;
      res.value      = W'(hi);
      res.saturation = (hi == 0) ? '0 : W'((r2h_pkg::FULL_SCALE * delta) / hi);
      // Grey and black leave hue at zero
      if (delta != 0) begin
        if (ri == hi) sec = r2h_pkg::SEC_RED;
        else if (gi == hi) sec = r2h_pkg::SEC_GREEN;
        else sec = r2h_pkg::SEC_BLUE;
        case (sec)
          r2h_pkg::SEC_RED: begin
            base = 0;
            diff = gi - bi;
          end
          r2h_pkg::SEC_GREEN: begin
            base = r2h_pkg::HUE_BASE_GREEN;
            diff = bi - ri;
          end
          default: begin
            base = r2h_pkg::HUE_BASE_BLUE;
            diff = ri - gi;
          end
        endcase
        hue = base + (r2h_pkg::HUE_SECTOR * diff) / delta;
      end
      res.hue = W'(hue);
      return res;
    endfunction

    function void note_pixel(logic [W-1:0] r, logic [W-1:0] g, logic [W-1:0] b);
      pending_hsv.push_back(pixel_to_hsv(r, g, b));
      pixels_in++;
    endfunction

    function void check_result(logic [W-1:0] hue, logic [W-1:0] sat, logic [W-1:0] val);
      hsv_t want;
      results_seen++;
      if (pending_hsv.size() == 0) begin
        $error("result beat with no pixel outstanding (hue %0d sat %0d value %0d)",
               hue, sat, val);
        mismatches++;
        return;
      end
      want = pending_hsv.pop_front();
      if (hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, hue);
        mismatches++;
      end
      if (sat !== want.saturation) begin
        $error("saturation: expected %0d, got %0d", want.saturation, sat);
        mismatches++;
      end
      if (val !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, val);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         in_valid  = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_red    = '0;
  logic [W-1:0] in_green  = '0;
  logic [W-1:0] in_blue   = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_hue;
  logic [W-1:0] out_saturation;
  logic [W-1:0] out_value;

  hsv_scoreboard sb;
  stall_mode_t   stall_mode = STALL_NONE;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;

  rgb_to_hsv_8bit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output back-pressure: switches between free-running, light, heavy and periodic stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 3 == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_hue, out_saturation, out_value);
    end
  end

  // Present one pixel and hold it until the beat is taken
  task automatic send_pixel(input logic [W-1:0] r, input logic [W-1:0] g,
                            input logic [W-1:0] b);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(r, g, b);
  endtask

  task automatic idle(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the sender until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_hsv.size() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rail_level();
    int unsigned sel;
    sel = $urandom_range(0, 2);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return W'($urandom_range(0, 255));
  endfunction

  // Random pixel, biased towards greys, ties for the maximum, the rails and dark pixels
  task automatic random_pixel(output logic [W-1:0] r, output logic [W-1:0] g,
                              output logic [W-1:0] b);
    logic [W-1:0] lvl;
    pix_kind_t    kind;
    lvl  = W'($urandom_range(0, 255));
    kind = pix_kind_t'($urandom_range(0, 5));
    r = W'($urandom_range(0, 255));
    g = W'($urandom_range(0, 255));
    b = W'($urandom_range(0, 255));
    case (kind)
      PIX_NEAR_GREY: begin
        r = lvl;
        g = lvl + W'($urandom_range(0, 3));
        b = lvl - W'($urandom_range(0, 3));
      end
      PIX_TIE: begin
        case ($urandom_range(0, 2))
          0: begin r = lvl; g = lvl; b = W'($urandom_range(0, lvl)); end
          1: begin g = lvl; b = lvl; r = W'($urandom_range(0, lvl)); end
          default: begin r = lvl; b = lvl; g = W'($urandom_range(0, lvl)); end
        endcase
      end
      PIX_RAIL: begin
        r = rail_level();
        g = rail_level();
        b = rail_level();
      end
      PIX_DARK: begin
        r = W'($urandom_range(0, 7));
        g = W'($urandom_range(0, 7));
        b = W'($urandom_range(0, 7));
      end
      PIX_GREY: begin
        r = lvl;
        g = lvl;
        b = lvl;
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [W-1:0] r, g, b;
    int unsigned  sent, burst, gap;
    bit           held_off;
    sb       = new();
    sent     = 0;
    held_off = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    send_pixel(8'd0,   8'd0,   8'd0);     // black
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);     // pure red
    send_pixel(8'd0,   8'd255, 8'd0);     // pure green
    send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
    send_pixel(8'd255, 8'd0,   8'd128);   // red sector, hue wraps below zero
    send_pixel(8'd100, 8'd0,   8'd1);     // negative quotient truncates to zero
    send_pixel(8'd0,   8'd255, 8'd128);   // green sector
    send_pixel(8'd128, 8'd0,   8'd255);   // blue sector
    send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie goes to red
    send_pixel(8'd0,   8'd200, 8'd200);   // green/blue tie goes to green
    send_pixel(8'd200, 8'd0,   8'd200);   // red/blue tie goes to red
    send_pixel(8'd255, 8'd255, 8'd254);   // minimum saturation
    send_pixel(8'd1,   8'd0,   8'd0);     // darkest colour
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd170, 8'd85,  8'd255);   // blue sector, positive diff
    send_pixel(8'd255, 8'd1,   8'd0);     // red sector, small positive diff truncates to zero hue
    wait_drained();

    // Random bursts with random gaps; one hold-off until empty half way through
    while (sent < RANDOM_PIXELS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int unsigned i = 0; i < burst && sent < RANDOM_PIXELS; i++) begin
        random_pixel(r, g, b);
        send_pixel(r, g, b);
        sent++;
      end
      if (!held_off && sent >= RANDOM_PIXELS / 2) begin
        held_off = 1'b1;
        wait_drained();
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) idle(gap);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d random), checked %0d result beats, %0d mismatches",
             sb.pixels_in, sent, sb.results_seen, sb.mismatches);
    $display("Covered black, grey, tie-break and hue-wrap cases under bursty input and stalls");
    if (sb.mismatches == 0 && sb.pending_hsv.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
